### hdl/nwsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_pkg: shared types and constants
// widths, codes and datapath commands of the normalised weighted-sum neuron
// ----------------------------------------------------------------------------
package nwsn_pkg;

  localparam int MAX_INPUTS = 64;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 16;
  localparam int LEN_W      = 7;
  localparam int LR_W       = 16;
  localparam int S_W        = 24;
  localparam int W_W        = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_AW     = 32;
  localparam int MUL_BW     = 24;
  localparam int MUL_PW     = MUL_AW + MUL_BW;
  localparam int DIV_NW     = 58;
  localparam int DIV_DW     = 47;
  localparam int ITER_W     = $clog2(DIV_NW + 1);
  localparam int DMAG_W     = 41;
  localparam int DELTA_W    = 18;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FWD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BWD  = 2'd2;

  localparam logic RES_FWD = 1'b0;
  localparam logic RES_BWD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
  localparam logic [LR_W-1:0]  LR_RESET  = 16'd655;

  localparam logic signed [S_W-1:0] S_MAX = {1'b0, {(S_W-1){1'b1}}};
  localparam logic signed [S_W-1:0] S_MIN = {1'b1, {(S_W-1){1'b0}}};
  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_LOAD_WR,
    OP_FWD_MUL,
    OP_FWD_ACC,
    OP_FWD_DIV,
    OP_EMIT_FWD,
    OP_EMIT_ZERO,
    OP_B_WS,
    OP_B_D,
    OP_B_ELO,
    OP_B_EHI,
    OP_B_NUM,
    OP_B_SQ,
    OP_B_DIV1,
    OP_B_RE,
    OP_B_REV,
    OP_B_DIV2,
    OP_B_UPD,
    OP_EMIT_BWD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              is_last;
    logic              s_zero;
    logic              div_busy;
  } dp_stat_t;

  // signed saturation of a sign and magnitude quotient to 16 bits
  function automatic logic signed [VAL_W-1:0] sat16(input logic neg,
                                                   input logic [DIV_NW-1:0] mag);
    logic signed [VAL_W-1:0] r;
    if (!neg) begin
      r = (mag > DIV_NW'(32767)) ? 16'sh7fff : signed'(mag[VAL_W-1:0]);
    end else begin
      r = (mag > DIV_NW'(32768)) ? 16'sh8000 : signed'(VAL_W'(-mag[VAL_W-1:0]));
    end
    return r;
  endfunction

endpackage

### hdl/nwsn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_if: word channels
// input item channel and result channel with valid / ready handshake
// ----------------------------------------------------------------------------
interface nwsn_in_if;
  import nwsn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  error_in;

  modport source (output valid, kind, position, value, error_in, input ready);
  modport sink   (input valid, kind, position, value, error_in, output ready);
endinterface

interface nwsn_out_if;
  import nwsn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [POS_W-1:0]         result_position;
  logic signed [VAL_W-1:0]  result_value;
  logic                     zero_sum;

  modport source (output valid, result_kind, result_position, result_value, zero_sum,
                  input ready);
  modport sink   (input valid, result_kind, result_position, result_value, zero_sum,
                  output ready);
endinterface

### hdl/nwsn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_div: restoring divider
// unsigned magnitude divide, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nwsn_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nwsn_pkg::DIV_NW-1:0] num_i,
  input  logic [nwsn_pkg::DIV_DW-1:0] den_i,
  output logic                        busy_o,
  output logic [nwsn_pkg::DIV_NW-1:0] quot_o
);
  import nwsn_pkg::*;

  logic [DIV_DW-1:0] den_q, rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ITER_W'(DIV_NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule

### hdl/nwsn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_dp: neuron datapath
// weight memory, sums, shared multiplier, divider and result register
// ----------------------------------------------------------------------------
module nwsn_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nwsn_pkg::dp_cmd_t               cmd_i,
  output nwsn_pkg::dp_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [nwsn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nwsn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [nwsn_pkg::KIND_W-1:0]     kind_i,
  input  logic [nwsn_pkg::POS_W-1:0]      position_i,
  input  logic signed [nwsn_pkg::VAL_W-1:0] value_i,
  input  logic signed [nwsn_pkg::VAL_W-1:0] error_in_i,
  output logic                            result_kind_o,
  output logic [nwsn_pkg::POS_W-1:0]      result_position_o,
  output logic signed [nwsn_pkg::VAL_W-1:0] result_value_o,
  output logic                            zero_sum_o
);
  import nwsn_pkg::*;

  dp_op_e op;
  assign op = cmd_i.op;

  // item and configuration registers
  logic [KIND_W-1:0]       kind_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q, err_q;
  logic [LEN_W-1:0]        len_q;
  logic [LR_W-1:0]         rate_q;
  logic signed [S_W-1:0]   s_q;
  logic signed [W_W-1:0]   w_q;

  // weight memory
  logic [VAL_W-1:0]        wmem [MAX_INPUTS];
  logic [VAL_W-1:0]        rdata_q;
  logic                    mem_we;
  logic [VAL_W-1:0]        mem_wd;
  logic signed [VAL_W-1:0] w_rd;

  // arithmetic registers
  logic [MUL_PW-1:0]       prod_q;
  logic [39:0]             lo_q;
  logic [DMAG_W-1:0]       dmag_q;
  logic                    dsign_q;
  logic [DIV_NW-1:0]       num_q;
  logic                    div_sign_q;
  logic signed [VAL_W-1:0] contrib_q;

  logic                    res_kind_q, zero_q;
  logic [POS_W-1:0]        res_pos_q;
  logic signed [VAL_W-1:0] res_val_q;

  logic [LEN_W-1:0]        n_used;
  logic [VAL_W-1:0]        val_mag, err_mag, w_mag;
  logic [S_W-1:0]          s_mag;
  logic [W_W-1:0]          wsum_mag;
  logic [MUL_AW-1:0]       mul_a;
  logic [MUL_BW-1:0]       mul_b;
  logic                    mul_en;

  logic signed [S_W-1:0]   base_s, s_new;
  logic signed [W_W-1:0]   base_w, w_new;
  logic signed [S_W:0]     s_sum;
  logic [W_W:0]            p_mag;
  logic signed [W_W:0]     p_term, w_sum;
  logic [W_W+1:0]          ws_mag;
  logic signed [W_W+1:0]   ws, d;
  logic [DIV_NW-3:0]       num_sum;

  logic                    div_start, div_busy;
  logic [DIV_NW-1:0]       div_num, div_quot;
  logic [DIV_DW-1:0]       div_den;
  logic                    div_neg;

  logic [DELTA_W-1:0]      dm;
  logic signed [DELTA_W:0] delta;
  logic signed [DELTA_W+1:0] upd_sum;
  logic signed [VAL_W-1:0] upd_w;

  assign w_rd     = signed'(rdata_q);
  assign val_mag  = val_q[VAL_W-1] ? VAL_W'(-val_q) : VAL_W'(val_q);
  assign err_mag  = err_q[VAL_W-1] ? VAL_W'(-err_q) : VAL_W'(err_q);
  assign w_mag    = w_rd[VAL_W-1]  ? VAL_W'(-w_rd)  : VAL_W'(w_rd);
  assign s_mag    = s_q[S_W-1]     ? S_W'(-s_q)     : S_W'(s_q);
  assign wsum_mag = w_q[W_W-1]     ? W_W'(-w_q)     : W_W'(w_q);

  // zero acts as one, anything above the store size as the store size
  always_comb begin
    if (len_q == '0) begin
      n_used = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_INPUTS)) begin
      n_used = LEN_W'(MAX_INPUTS);
    end else begin
      n_used = len_q;
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.in_range = LEN_W'(pos_q) < n_used;
  assign stat_o.is_last  = LEN_W'(pos_q) == (n_used - 1'b1);
  assign stat_o.s_zero   = s_q == '0;
  assign stat_o.div_busy = div_busy;

  // multiplier operand selection
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_FWD_MUL: begin
        mul_a = MUL_AW'(val_mag);
        mul_b = MUL_BW'(w_mag);
      end
      OP_B_WS: begin
        mul_a = MUL_AW'(w_mag);
        mul_b = s_mag;
      end
      OP_B_ELO: begin
        mul_a = MUL_AW'(err_mag);
        mul_b = dmag_q[MUL_BW-1:0];
      end
      OP_B_EHI: begin
        mul_a = MUL_AW'(err_mag);
        mul_b = MUL_BW'(dmag_q[DMAG_W-1:MUL_BW]);
      end
      OP_B_SQ: begin
        mul_a = MUL_AW'(s_mag);
        mul_b = s_mag;
      end
      OP_B_RE: begin
        mul_a = MUL_AW'(rate_q);
        mul_b = MUL_BW'(err_mag);
      end
      OP_B_REV: begin
        mul_a = prod_q[MUL_AW-1:0];
        mul_b = MUL_BW'(val_mag);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // forward accumulation with saturation, position zero starts a pass
  always_comb begin
    base_s = (pos_q == '0) ? '0 : s_q;
    base_w = (pos_q == '0) ? '0 : w_q;
    s_sum  = (S_W+1)'(base_s) + (S_W+1)'(val_q);
    if (s_sum[S_W] != s_sum[S_W-1]) begin
      s_new = s_sum[S_W] ? S_MIN : S_MAX;
    end else begin
      s_new = s_sum[S_W-1:0];
    end
    p_mag  = (W_W+1)'(prod_q[31:0]);
    p_term = (val_q[VAL_W-1] ^ w_rd[VAL_W-1]) ? -signed'(p_mag) : signed'(p_mag);
    w_sum  = (W_W+1)'(base_w) + p_term;
    if (w_sum[W_W] != w_sum[W_W-1]) begin
      w_new = w_sum[W_W] ? W_MIN : W_MAX;
    end else begin
      w_new = w_sum[W_W-1:0];
    end
  end

  // w*S - W and the scaled error numerator
  always_comb begin
    ws_mag  = (W_W+2)'(prod_q[38:0]);
    ws      = (w_rd[VAL_W-1] ^ s_q[S_W-1]) ? -signed'(ws_mag) : signed'(ws_mag);
    d       = ws - (W_W+2)'(w_q);
    num_sum = (DIV_NW-2)'({prod_q[31:0], lo_q[MUL_BW-1:0] & '0}) + (DIV_NW-2)'(lo_q);
  end

  // weight update, delta magnitude capped well beyond the weight range
  always_comb begin
    dm      = (div_quot > DIV_NW'(1 << (DELTA_W-1))) ? DELTA_W'(1 << (DELTA_W-1))
                                                     : div_quot[DELTA_W-1:0];
    delta   = div_sign_q ? -signed'((DELTA_W+1)'(dm)) : signed'((DELTA_W+1)'(dm));
    upd_sum = (DELTA_W+2)'(w_rd) + (DELTA_W+2)'(delta);
    if (upd_sum > (DELTA_W+2)'(32767)) begin
      upd_w = 16'sh7fff;
    end else if (upd_sum < -(DELTA_W+2)'(32768)) begin
      upd_w = 16'sh8000;
    end else begin
      upd_w = upd_sum[VAL_W-1:0];
    end
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    case (op)
      OP_FWD_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(wsum_mag);
        div_den   = DIV_DW'(s_mag);
        div_neg   = w_q[W_W-1] ^ s_q[S_W-1];
      end
      OP_B_DIV1: begin
        div_start = 1'b1;
        div_num   = num_q;
        div_den   = prod_q[DIV_DW-1:0];
        div_neg   = err_q[VAL_W-1] ^ dsign_q;
      end
      OP_B_DIV2: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(prod_q[DIV_DW-1:0]);
        div_den   = DIV_DW'({s_mag, 16'b0});
        div_neg   = err_q[VAL_W-1] ^ val_q[VAL_W-1] ^ s_q[S_W-1];
      end
      default: div_start = 1'b0;
    endcase
  end

  nwsn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign mem_we = (op == OP_LOAD_WR) || (op == OP_B_UPD);
  assign mem_wd = (op == OP_LOAD_WR) ? VAL_W'(val_q) : VAL_W'(upd_w);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wmem[pos_q] <= mem_wd;
    end
    rdata_q <= wmem[pos_q];
  end

  // control-carrying state: configuration and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      rate_q <= LR_RESET;
      s_q    <= '0;
      w_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_LENGTH: len_q  <= cfg_data_i[LEN_W-1:0];
          CFG_LEARNING_RATE: rate_q <= cfg_data_i[LR_W-1:0];
          default:           len_q  <= len_q;
        endcase
      end
      if (op == OP_FWD_ACC) begin
        s_q <= s_new;
        w_q <= w_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op == OP_LATCH) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= value_i;
      err_q  <= error_in_i;
    end
    if (mul_en) begin
      prod_q <= MUL_PW'(mul_a) * MUL_PW'(mul_b);
    end
    if (div_start) begin
      div_sign_q <= div_neg;
    end
    case (op)
      OP_B_D: begin
        dmag_q  <= d[W_W+1] ? DMAG_W'(-d) : DMAG_W'(d);
        dsign_q <= d[W_W+1];
      end
      OP_B_EHI: lo_q  <= prod_q[39:0];
      OP_B_NUM: num_q <= {num_sum, 2'b00};
      OP_B_RE:  contrib_q <= sat16(div_sign_q, div_quot);
      OP_EMIT_FWD: begin
        res_kind_q <= RES_FWD;
        res_pos_q  <= '0;
        res_val_q  <= sat16(div_sign_q, div_quot);
        zero_q     <= 1'b0;
      end
      OP_EMIT_BWD: begin
        res_kind_q <= RES_BWD;
        res_pos_q  <= pos_q;
        res_val_q  <= contrib_q;
        zero_q     <= 1'b0;
      end
      OP_EMIT_ZERO: begin
        res_kind_q <= (kind_q == KIND_FWD) ? RES_FWD : RES_BWD;
        res_pos_q  <= (kind_q == KIND_FWD) ? '0 : pos_q;
        res_val_q  <= '0;
        zero_q     <= 1'b1;
      end
      default: zero_q <= zero_q;
    endcase
  end

  assign result_kind_o     = res_kind_q;
  assign result_position_o = res_pos_q;
  assign result_value_o    = res_val_q;
  assign zero_sum_o        = zero_q;
endmodule

### hdl/nwsn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_ctrl: neuron sequencer
// steps the datapath through load, forward and backward items
// ----------------------------------------------------------------------------
module nwsn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  nwsn_pkg::dp_stat_t stat_i,
  output nwsn_pkg::dp_cmd_t  cmd_o
);
  import nwsn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_READ,
    S_FWD_MUL, S_FWD_ACC, S_FWD_CHK, S_FWD_DIV, S_FWD_EMIT,
    S_B_ZERO, S_B_WS, S_B_D, S_B_ELO, S_B_EHI, S_B_NUM, S_B_SQ,
    S_B_DIV1, S_B_W1, S_B_RE, S_B_REV, S_B_DIV2, S_B_W2, S_B_UPD, S_B_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  dp_op_e op;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;

  always_comb begin
    op = OP_IDLE;
    case (state_q)
      S_IDLE:     op = in_valid_i ? OP_LATCH : OP_IDLE;
      S_READ:     op = (stat_i.kind == KIND_LOAD) ? OP_LOAD_WR : OP_IDLE;
      S_FWD_MUL:  op = OP_FWD_MUL;
      S_FWD_ACC:  op = OP_FWD_ACC;
      S_FWD_CHK: begin
        if (!stat_i.s_zero) begin
          op = OP_FWD_DIV;
        end else if (out_free) begin
          op = OP_EMIT_ZERO;
        end
      end
      S_FWD_EMIT: op = out_free ? OP_EMIT_FWD : OP_IDLE;
      S_B_ZERO:   op = out_free ? OP_EMIT_ZERO : OP_IDLE;
      S_B_WS:     op = OP_B_WS;
      S_B_D:      op = OP_B_D;
      S_B_ELO:    op = OP_B_ELO;
      S_B_EHI:    op = OP_B_EHI;
      S_B_NUM:    op = OP_B_NUM;
      S_B_SQ:     op = OP_B_SQ;
      S_B_DIV1:   op = OP_B_DIV1;
      S_B_RE:     op = OP_B_RE;
      S_B_REV:    op = OP_B_REV;
      S_B_DIV2:   op = OP_B_DIV2;
      S_B_UPD:    op = OP_B_UPD;
      S_B_EMIT:   op = out_free ? OP_EMIT_BWD : OP_IDLE;
      default:    op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (op == OP_EMIT_FWD || op == OP_EMIT_BWD || op == OP_EMIT_ZERO) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (stat_i.kind == KIND_FWD && stat_i.in_range) begin
            state_q <= S_FWD_MUL;
          end else if (stat_i.kind == KIND_BWD && stat_i.in_range) begin
            state_q <= stat_i.s_zero ? S_B_ZERO : S_B_WS;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FWD_MUL: state_q <= S_FWD_ACC;
        S_FWD_ACC: state_q <= stat_i.is_last ? S_FWD_CHK : S_IDLE;
        S_FWD_CHK: begin
          if (!stat_i.s_zero) begin
            state_q <= S_FWD_DIV;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_FWD_DIV: begin
          if (!stat_i.div_busy) begin
            state_q <= S_FWD_EMIT;
          end
        end
        S_FWD_EMIT, S_B_ZERO, S_B_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_B_WS:   state_q <= S_B_D;
        S_B_D:    state_q <= S_B_ELO;
        S_B_ELO:  state_q <= S_B_EHI;
        S_B_EHI:  state_q <= S_B_NUM;
        S_B_NUM:  state_q <= S_B_SQ;
        S_B_SQ:   state_q <= S_B_DIV1;
        S_B_DIV1: state_q <= S_B_W1;
        S_B_W1: begin
          if (!stat_i.div_busy) begin
            state_q <= S_B_RE;
          end
        end
        S_B_RE:   state_q <= S_B_REV;
        S_B_REV:  state_q <= S_B_DIV2;
        S_B_DIV2: state_q <= S_B_W2;
        S_B_W2: begin
          if (!stat_i.div_busy) begin
            state_q <= S_B_UPD;
          end
        end
        S_B_UPD:  state_q <= S_B_EMIT;
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/normalized_weighted_sum_neuron_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_weighted_sum_neuron_unit: normalised weighted-sum output neuron
// weight store, running sums, W/S forward result and backward contributions
// ----------------------------------------------------------------------------
//
//  channel    direction  words carried
//  item_in    sink       kind, position, value, error_in
//  item_out   source     result_kind, result_position, result_value, zero_sum
//  cfg        write      active_length (index 0), learning_rate (index 1)
//
// one item at a time: a new item is taken only once the sequencer is idle;
// the last forward word of a pass and each backward word with a nonzero
// sum wait on the 58-step restoring divider
// reset clears the sums and sets the configuration to its reset values, the weight store is not cleared
// a result waits in the output register; a stalled sink only holds the block
// once the next result is ready to be written
//
module normalized_weighted_sum_neuron_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nwsn_in_if.sink                         item_in,
  nwsn_out_if.source                      item_out,
  input  logic                            cfg_we_i,
  input  logic [nwsn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nwsn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nwsn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: handshakes and step order
  nwsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in.valid),
    .in_ready_o  (item_in.ready),
    .out_valid_o (item_out.valid),
    .out_ready_i (item_out.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: memory, multiplier, divider, result register
  nwsn_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (item_in.kind),
    .position_i        (item_in.position),
    .value_i           (item_in.value),
    .error_in_i        (item_in.error_in),
    .result_kind_o     (item_out.result_kind),
    .result_position_o (item_out.result_position),
    .result_value_o    (item_out.result_value),
    .zero_sum_o        (item_out.zero_sum)
  );
endmodule

### hdl/nwsn_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwsn_chk: port checker
// handshake and result rules seen at the neuron ports
// ----------------------------------------------------------------------------
module nwsn_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              out_kind_i,
  input logic [nwsn_pkg::POS_W-1:0]        out_pos_i,
  input logic signed [nwsn_pkg::VAL_W-1:0] out_val_i,
  input logic                              out_zero_i
);
  import nwsn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_val_i) && $stable(out_pos_i))
    else $error("result changed while stalled");

  a_fwd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == RES_FWD |-> out_pos_i == '0)
    else $error("forward result with nonzero position");

  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_zero_i |-> out_val_i == '0)
    else $error("zero sum with nonzero value");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while busy");
endmodule

bind normalized_weighted_sum_neuron_unit nwsn_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_in.valid),
  .in_ready_i  (item_in.ready),
  .out_valid_i (item_out.valid),
  .out_ready_i (item_out.ready),
  .out_kind_i  (item_out.result_kind),
  .out_pos_i   (item_out.result_position),
  .out_val_i   (item_out.result_value),
  .out_zero_i  (item_out.zero_sum)
);

### bench/normalized_weighted_sum_neuron_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_weighted_sum_neuron_unit_checker: result predictor and scoreboard
// watches the item, result and register ports, predicts each result word
// from its own copy of the weights, sums and registers, compares in order
// ----------------------------------------------------------------------------
module normalized_weighted_sum_neuron_unit_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nwsn_in_if                              item_in,
  nwsn_out_if                             item_out,
  input  logic                            cfg_we_i,
  input  logic [nwsn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nwsn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import nwsn_pkg::*;

  typedef struct packed {
    logic                    kind;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic                    zero;
  } neuron_word_t;

  logic signed [VAL_W-1:0] weight_mem [MAX_INPUTS];
  longint                  act_sum;
  longint                  wsum;
  logic [LEN_W-1:0]        len_reg;
  logic [LR_W-1:0]         rate_reg;
  neuron_word_t            neuron_results_q [$];
  int                      fails;

  assign fail_count_o = fails;
  assign pending_o    = neuron_results_q.size();

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one input word through the neuron, returns 1 when it yields a result
  function automatic bit neuron_step(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] pos,
                                     input logic signed [VAL_W-1:0] val,
                                     input logic signed [VAL_W-1:0] err,
                                     output neuron_word_t w);
    longint x, e, sm, wt, d, res, num, delta;
    int     n;
    bit     zero;
    x    = val;
    e    = err;
    res  = 0;
    w    = '0;
    n    = (len_reg == 0) ? 1 : ((len_reg > MAX_INPUTS) ? MAX_INPUTS : int'(len_reg));
    if (kind == KIND_LOAD) begin
      weight_mem[pos] = val;
      return 0;
    end
    if ((kind != KIND_FWD && kind != KIND_BWD) || pos >= n) return 0;
    if (kind == KIND_FWD) begin
      if (pos == 0) begin
        act_sum = 0;
        wsum    = 0;
      end
      act_sum = clamp(act_sum + x, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
      wsum    = clamp(wsum + x * longint'(weight_mem[pos]),
                      -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
      if (pos != n - 1) return 0;
      zero = (act_sum == 0);
      if (!zero) begin
        sm  = (act_sum < 0) ? -act_sum : act_sum;
        res = wsum / sm;
        if (act_sum < 0) res = -res;
      end
      w.kind = RES_FWD;
      w.pos  = '0;
    end else begin
      zero = (act_sum == 0);
      if (!zero) begin
        sm    = (act_sum < 0) ? -act_sum : act_sum;
        wt    = weight_mem[pos];
        d     = wt * act_sum - wsum;
        res   = (e * d * 4) / (sm * sm);
        num   = longint'(rate_reg) * e * x;
        delta = num / (sm <<< 16);
        if (act_sum < 0) delta = -delta;
        weight_mem[pos] = VAL_W'(clamp(wt + delta, -32768, 32767));
      end
      w.kind = RES_BWD;
      w.pos  = pos;
    end
    w.value = VAL_W'(clamp(res, -32768, 32767));
    w.zero  = zero;
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_word_t w, got;
    if (!rst_ni) begin
      act_sum  = 0;
      wsum     = 0;
      len_reg  = LEN_RESET;
      rate_reg = LR_RESET;
      fails    = 0;
      neuron_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE_LENGTH) len_reg = cfg_data_i[LEN_W-1:0];
        else rate_reg = cfg_data_i[LR_W-1:0];
      end
      if (item_out.valid && item_out.ready) begin
        got = '{item_out.result_kind, item_out.result_position,
                item_out.result_value, item_out.zero_sum};
        if (neuron_results_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none actual %h", $time, got);
        end else begin
          w = neuron_results_q.pop_front();
          if (got.kind !== w.kind) begin
            fails++;
            $display("%0t: result_kind expected %0d actual %0d", $time, w.kind, got.kind);
          end
          if (got.pos !== w.pos) begin
            fails++;
            $display("%0t: result_position expected %0d actual %0d", $time, w.pos, got.pos);
          end
          if (got.value !== w.value) begin
            fails++;
            $display("%0t: result_value expected %0d actual %0d", $time, w.value,
                     got.value);
          end
          if (got.zero !== w.zero) begin
            fails++;
            $display("%0t: zero_sum expected %0d actual %0d", $time, w.zero, got.zero);
          end
        end
      end
      if (item_in.valid && item_in.ready) begin
        if (neuron_step(item_in.kind, item_in.position, item_in.value,
                        item_in.error_in, w))
          neuron_results_q.push_back(w);
      end
    end
  end

endmodule

### bench/normalized_weighted_sum_neuron_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_weighted_sum_neuron_unit_tb: neuron unit testbench
// loads every weight, runs directed corner words, then random forward and
// backward passes over many register settings with random stalls on both
// channels; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module normalized_weighted_sum_neuron_unit_tb;
  import nwsn_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1200;
  localparam int SETTLE_CYC   = 200;       // longer than a backward word
  localparam int CYCLE_LIMIT  = 1500000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  int                    sent;
  bit                    quiet;   // no idling on either side while set
  int                    eff_len;

  nwsn_in_if  item_in ();
  nwsn_out_if item_out ();

  normalized_weighted_sum_neuron_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (item_in),
    .item_out   (item_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  normalized_weighted_sum_neuron_unit_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_in      (item_in),
    .item_out     (item_out),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle counter guarding against a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("normalized_weighted_sum_neuron_unit test failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  // result sink: random stall before every word
  initial begin
    int gap;
    item_out.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        item_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      item_out.ready <= 1'b1;
      do @(posedge clk_i); while (!item_out.valid);
    end
  end

  // one input word; valid stays high into the next word when there is no gap
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] err);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_in.valid    <= 1'b1;
    item_in.kind     <= kind;
    item_in.position <= pos;
    item_in.value    <= val;
    item_in.error_in <= err;
    do @(posedge clk_i); while (!item_in.ready);
    sent++;
  endtask

  // wait for every result, then for a word that gives none to drain
  task automatic settle();
    item_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_length(input logic [CFG_DATA_W-1:0] d);
    logic [LEN_W-1:0] l;
    l = d[LEN_W-1:0];
    write_reg(CFG_ACTIVE_LENGTH, d);
    eff_len = (l == 0) ? 1 : ((l > MAX_INPUTS) ? MAX_INPUTS : int'(l));
  endtask

  // well-formed pass: sometimes a load word, forward 0..n-1, then up to four backward words
  task automatic run_pass();
    logic [VAL_W-1:0] x0;
    int               nb;
    if ($urandom_range(0, 3) == 0)
      send_word(KIND_LOAD, POS_W'($urandom_range(0, MAX_INPUTS - 1)), VAL_W'($urandom),
                VAL_W'($urandom));
    x0 = VAL_W'($urandom);
    for (int p = 0; p < eff_len; p++) begin
      // now and then cancel the sum to reach the zero-sum path
      if (eff_len == 2 && p == 1 && $urandom_range(0, 3) == 0)
        send_word(KIND_FWD, POS_W'(p), VAL_W'(-x0), VAL_W'($urandom));
      else if (p == 0)
        send_word(KIND_FWD, POS_W'(p), x0, VAL_W'($urandom));
      else if ($urandom_range(0, 1))
        send_word(KIND_FWD, POS_W'(p), VAL_W'($urandom), VAL_W'($urandom));
      else
        send_word(KIND_FWD, POS_W'(p), VAL_W'($urandom_range(0, 255) - 128),
                  VAL_W'($urandom));
    end
    nb = $urandom_range(0, 4);
    for (int b = 0; b < nb; b++)
      send_word(KIND_BWD, POS_W'($urandom_range(0, eff_len - 1)), VAL_W'($urandom),
                VAL_W'($urandom));
  endtask

  // noise: any kind, any position
  task automatic run_noise();
    int k;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++)
      send_word(KIND_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, MAX_INPUTS - 1)),
                VAL_W'($urandom), VAL_W'($urandom));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lens [10];
    int                    sel;
    cycles           = 0;
    sent             = 0;
    quiet            = 1'b0;
    eff_len          = MAX_INPUTS;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    item_in.valid    = 1'b0;
    item_in.kind     = KIND_LOAD;
    item_in.position = '0;
    item_in.value    = '0;
    item_in.error_in = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every weight written before any is read
    for (int p = 0; p < MAX_INPUTS; p++)
      send_word(KIND_LOAD, POS_W'(p),
                (p == 1) ? 16'h7fff : ((p == 2) ? 16'h8000 : VAL_W'($urandom)), '0);
    // one full-length pass at the reset settings
    run_pass();
    settle();

    // directed corners: sum of -1, extreme errors, saturating update
    set_length(16'd2);
    write_reg(CFG_LEARNING_RATE, 16'hffff);
    send_word(KIND_FWD, 6'd0, 16'h7fff, '0);
    send_word(KIND_FWD, 6'd1, 16'h8000, 16'hffff);
    send_word(KIND_BWD, 6'd0, 16'h7fff, 16'h7fff);
    send_word(KIND_BWD, 6'd1, 16'h8000, 16'h8000);
    send_word(KIND_BWD, 6'd1, 16'h7fff, 16'h8000);
    send_word(KIND_UNUSED, 6'd0, 16'h7fff, 16'h7fff);
    send_word(KIND_FWD, 6'd2, 16'h1234, '0);       // beyond active length
    send_word(KIND_BWD, 6'd63, 16'h1234, 16'h0100);
    settle();
    // zero sum on forward and backward
    set_length(16'd1);
    send_word(KIND_FWD, 6'd0, '0, '0);
    send_word(KIND_BWD, 6'd0, 16'h4000, 16'h0005);
    send_word(KIND_LOAD, 6'd63, 16'h8000, '0);
    send_word(KIND_LOAD, 6'd0, 16'h7fff, '0);
    send_word(KIND_FWD, 6'd0, 16'h0001, '0);
    send_word(KIND_BWD, 6'd0, 16'h7fff, 16'h7fff);
    send_word(KIND_BWD, 6'd0, 16'h4000, '0);
    send_word(KIND_FWD, 6'd0, 16'h8000, '0);
    send_word(KIND_BWD, 6'd0, 16'h8000, 16'h8000);
    settle();

    // random phases, mostly short passes
    lens = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd64, 16'd0, 16'd100, 16'd127, 16'hff85};
    while (sent < ITEM_TARGET) begin
      settle();
      sel = $urandom_range(0, 19);
      if (sel < 10) set_length(lens[sel]);
      else set_length({9'($urandom_range(0, 511)), 7'($urandom_range(1, 16))});
      case ($urandom_range(0, 3))
        0: write_reg(CFG_LEARNING_RATE, 16'h0000);
        1: write_reg(CFG_LEARNING_RATE, 16'hffff);
        default: write_reg(CFG_LEARNING_RATE, CFG_DATA_W'($urandom));
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = $urandom_range(3, 8); i > 0 && sent < ITEM_TARGET; i--) begin
        if ($urandom_range(0, 6) == 0) run_noise();
        else run_pass();
      end
    end

    item_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("normalized_weighted_sum_neuron_unit test passed");
    else
      $display("normalized_weighted_sum_neuron_unit test failed");
    $finish;
  end

endmodule
